### sv/qrs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_pkg
// Widths, types and codes shared by the quadratic root solver pipeline.
// ----------------------------------------------------------------------------
package qrs_pkg;

	localparam int WORD_BITS = 32;
	localparam int FRAC_BITS = 16;

	// b*b + 4*|a*c| needs two bits more than a product, plus one carry
	localparam int DISC_W   = 2 * WORD_BITS + 3;
	localparam int SQ_PAIRS = (DISC_W + 2 * FRAC_BITS + 1) / 2;
	localparam int RAD_W    = 2 * SQ_PAIRS;
	localparam int ROOT_W   = SQ_PAIRS;
	localparam int REM_W    = ROOT_W + 2;
	localparam int P_W      = WORD_BITS + FRAC_BITS;
	localparam int NUM_W    = ((P_W > ROOT_W) ? P_W : ROOT_W) + 1;
	localparam int DEN_W    = WORD_BITS + 1;

	localparam int IN_W       = 3 * WORD_BITS;
	localparam int IN_TDATA_W = ((IN_W + 7) / 8) * 8;
	localparam int OUT_W      = 2 + 2 * WORD_BITS + 1;
	localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

	typedef enum logic [1:0] {
		K_NONE = 2'd0,
		K_ONE  = 2'd1,
		K_TWO  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t              kind;
		logic               pneg;
		logic [P_W-1:0]     pmag;
		logic               dneg;
		logic [DEN_W-1:0]   dmag;
	} sq_pay_t;

	typedef struct packed {
		logic [RAD_W-1:0]   rad;
		logic [REM_W-1:0]   rem;
		logic [ROOT_W-1:0]  root;
	} sq_st_t;

	typedef struct packed {
		kind_t              kind;
		logic               neg1;
		logic               neg2;
		logic [DEN_W-1:0]   dmag;
	} dv_pay_t;

	typedef struct packed {
		logic [DEN_W-1:0]   rem;
		logic [NUM_W-1:0]   nq;
	} lane_t;

	typedef struct packed {
		lane_t l1;
		lane_t l2;
	} dv_st_t;

	typedef struct packed {
		logic [1:0]                  count;
		logic signed [WORD_BITS-1:0] r1;
		logic signed [WORD_BITS-1:0] r2;
		logic                        sat;
	} res_t;

endpackage

### sv/qrs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_front
// Splits the coefficients into sign and magnitude, forms b*b and a*c, then
// decides the case and loads the square root chain.
// ----------------------------------------------------------------------------
module qrs_front import qrs_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [WORD_BITS-1:0] coef_a,
	input  logic [WORD_BITS-1:0] coef_b,
	input  logic [WORD_BITS-1:0] coef_c,
	output logic                 out_valid,
	output sq_pay_t              out_pay,
	output sq_st_t               out_st
);

	logic                   v_s1;
	logic                   na_s1, nb_s1, nc_s1;
	logic [WORD_BITS-1:0]   ma_s1, mb_s1, mc_s1;
	logic [2*WORD_BITS-1:0] b2_s1, ac_s1;
	logic [WORD_BITS-1:0]   ma, mb, mc;

	logic                   v_s2;
	sq_pay_t                pay_s2;
	sq_st_t                 st_s2;

	logic [DISC_W-1:0]      b2e, ac4e, d4;
	logic                   acneg, gt, eq;
	sq_pay_t                pay_d;
	logic [RAD_W-1:0]       rad_d;

	assign ma = coef_a[WORD_BITS-1] ? (~coef_a + 1'b1) : coef_a;
	assign mb = coef_b[WORD_BITS-1] ? (~coef_b + 1'b1) : coef_b;
	assign mc = coef_c[WORD_BITS-1] ? (~coef_c + 1'b1) : coef_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			na_s1 <= coef_a[WORD_BITS-1];
			nb_s1 <= coef_b[WORD_BITS-1];
			nc_s1 <= coef_c[WORD_BITS-1];
			ma_s1 <= ma;
			mb_s1 <= mb;
			mc_s1 <= mc;
			b2_s1 <= mb * mb;
			ac_s1 <= ma * mc;
		end
	end

	always_comb begin
		b2e   = DISC_W'(b2_s1);
		ac4e  = DISC_W'({ac_s1, 2'b00});
		acneg = (na_s1 != nc_s1) && (ac_s1 != '0);
		d4    = acneg ? (b2e + ac4e) : (b2e - ac4e);
		gt    = acneg || (b2e > ac4e);
		eq    = !acneg && (b2e == ac4e);

		pay_d.kind = K_NONE;
		pay_d.pneg = (mb_s1 != '0) && !nb_s1;
		pay_d.pmag = {mb_s1, {FRAC_BITS{1'b0}}};
		pay_d.dneg = na_s1;
		pay_d.dmag = {ma_s1, 1'b0};
		rad_d      = '0;
		if (ma_s1 == '0) begin
			// linear equation: root is -c/b
			pay_d.pneg = (mc_s1 != '0) && !nc_s1;
			pay_d.pmag = {mc_s1, {FRAC_BITS{1'b0}}};
			pay_d.dneg = nb_s1;
			pay_d.dmag = DEN_W'(mb_s1);
			if (mb_s1 != '0) begin
				pay_d.kind = K_ONE;
			end
		end else if (eq) begin
			pay_d.kind = K_ONE;
		end else if (gt) begin
			pay_d.kind = K_TWO;
			rad_d      = RAD_W'({d4, {2*FRAC_BITS{1'b0}}});
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_s2       <= pay_d;
			st_s2.rad    <= rad_d;
			st_s2.rem    <= '0;
			st_s2.root   <= '0;
		end
	end

	assign out_valid = v_s2;
	assign out_pay   = pay_s2;
	assign out_st    = st_s2;

endmodule

### sv/qrs_sqrt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_sqrt_cell
// One digit of a restoring square root: takes two radicand bits, yields one
// root bit, and hands the partial result to the next cell.
// ----------------------------------------------------------------------------
module qrs_sqrt_cell import qrs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  logic    in_valid,
	input  sq_pay_t in_pay,
	input  sq_st_t  in_st,
	output logic    out_valid,
	output sq_pay_t out_pay,
	output sq_st_t  out_st
);

	logic           v_q;
	sq_pay_t        pay_q;
	sq_st_t         st_q;
	logic [REM_W+1:0] r2, t;
	logic           ge;
	sq_st_t         st_d;

	always_comb begin
		r2 = {in_st.rem, in_st.rad[RAD_W-1 -: 2]};
		t  = {2'b00, in_st.root, 2'b01};
		ge = (r2 >= t);
		st_d.rem  = ge ? REM_W'(r2 - t) : REM_W'(r2);
		st_d.root = {in_st.root[ROOT_W-2:0], ge};
		st_d.rad  = {in_st.rad[RAD_W-3:0], 2'b00};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_q <= in_pay;
			st_q  <= st_d;
		end
	end

	assign out_valid = v_q;
	assign out_pay   = pay_q;
	assign out_st    = st_q;

endmodule

### sv/qrs_div_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_div_cell
// One quotient bit of a restoring division, for both root numerators at once
// over the shared denominator.
// ----------------------------------------------------------------------------
module qrs_div_cell import qrs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  logic    in_valid,
	input  dv_pay_t in_pay,
	input  dv_st_t  in_st,
	output logic    out_valid,
	output dv_pay_t out_pay,
	output dv_st_t  out_st
);

	function automatic lane_t div_step(lane_t x, logic [DEN_W-1:0] d);
		logic [DEN_W:0] r;
		lane_t          y;
		r    = {x.rem, x.nq[NUM_W-1]};
		y.nq = {x.nq[NUM_W-2:0], 1'b0};
		if (r >= {1'b0, d}) begin
			r       = r - {1'b0, d};
			y.nq[0] = 1'b1;
		end
		y.rem = r[DEN_W-1:0];
		return y;
	endfunction

	logic    v_q;
	dv_pay_t pay_q;
	dv_st_t  st_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_q   <= in_pay;
			st_q.l1 <= div_step(in_st.l1, in_pay.dmag);
			st_q.l2 <= div_step(in_st.l2, in_pay.dmag);
		end
	end

	assign out_valid = v_q;
	assign out_pay   = pay_q;
	assign out_st    = st_q;

endmodule

### sv/qrs_round.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qrs_round
// Rounds both quotients to nearest (ties away from zero), applies the sign,
// saturates to the word range and sets the root count.
// ----------------------------------------------------------------------------
module qrs_round import qrs_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    en,
	input  logic    in_valid,
	input  dv_pay_t in_pay,
	input  dv_st_t  in_st,
	output logic    out_valid,
	output res_t    out_res
);

	localparam logic [NUM_W:0] LIM_POS = (NUM_W+1)'((64'd1 << (WORD_BITS - 1)) - 64'd1);
	localparam logic [NUM_W:0] LIM_NEG = (NUM_W+1)'(64'd1 << (WORD_BITS - 1));

	logic v_q;
	res_t res_q;
	res_t res_d;
	logic sat1, sat2;

	function automatic logic [WORD_BITS:0] fin(lane_t x, logic neg, logic [DEN_W-1:0] d);
		logic [NUM_W:0]     q, lim;
		logic               s;
		logic [WORD_BITS-1:0] m;
		q   = {1'b0, x.nq} + (NUM_W+1)'({x.rem, 1'b0} >= {1'b0, d});
		lim = neg ? LIM_NEG : LIM_POS;
		s   = (q > lim);
		m   = s ? lim[WORD_BITS-1:0] : q[WORD_BITS-1:0];
		return {s, neg ? (~m + 1'b1) : m};
	endfunction

	always_comb begin
		{sat1, res_d.r1} = fin(in_st.l1, in_pay.neg1, in_pay.dmag);
		{sat2, res_d.r2} = fin(in_st.l2, in_pay.neg2, in_pay.dmag);
		res_d.sat = sat1 || sat2;
		unique case (in_pay.kind)
			K_ONE:   res_d.count = 2'd1;
			K_TWO:   res_d.count = 2'd2;
			default: begin
				res_d.count = 2'd0;
				res_d.r1    = '0;
				res_d.r2    = '0;
				res_d.sat   = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (en) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= res_d;
		end
	end

	assign out_valid = v_q;
	assign out_res   = res_q;

endmodule

### sv/quadratic_root_solver.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_root_solver
// Real roots of a*x^2 + b*x + c = 0 in signed Q15.16, one triple per cycle when not stalled.
// ----------------------------------------------------------------------------
// channel  dir  tdata fields (lsb first)
// s_axis   in   coef_a[31:0] coef_b[63:32] coef_c[95:64]
// m_axis   out  root_count[1:0] root_low[33:2] root_high[65:34] saturated[66]
//
// one item enters per cycle while s_tready is high; each passes two front stages,
// one cell per root bit of the square root (50), a sum stage, one cell per
// quotient bit of the divider (51), the rounding stage and the output register.
// reset clears only valid bits; no warm-up pass.
// a result held at the output lets one more beat in through a skid register,
// after which the whole pipeline stalls until m_tready.
// ----------------------------------------------------------------------------
module quadratic_root_solver import qrs_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,   // coef_a, coef_b, coef_c
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata    // root_count, root_low, root_high, saturated
);

	logic en;

	logic    sq_v   [SQ_PAIRS+1];
	sq_pay_t sq_pay [SQ_PAIRS+1];
	sq_st_t  sq_st  [SQ_PAIRS+1];

	logic    dv_v   [NUM_W+1];
	dv_pay_t dv_pay [NUM_W+1];
	dv_st_t  dv_st  [NUM_W+1];

	qrs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (s_tvalid),
		.coef_a   (s_tdata[WORD_BITS-1:0]),
		.coef_b   (s_tdata[2*WORD_BITS-1:WORD_BITS]),
		.coef_c   (s_tdata[3*WORD_BITS-1:2*WORD_BITS]),
		.out_valid(sq_v[0]),
		.out_pay  (sq_pay[0]),
		.out_st   (sq_st[0])
	);

	for (genvar i = 0; i < SQ_PAIRS; i++) begin : g_sqrt
		qrs_sqrt_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (sq_v[i]),
			.in_pay   (sq_pay[i]),
			.in_st    (sq_st[i]),
			.out_valid(sq_v[i+1]),
			.out_pay  (sq_pay[i+1]),
			.out_st   (sq_st[i+1])
		);
	end

	// numerators -b*2^F -/+ s, as sign and magnitude
	logic signed [NUM_W:0] pp, se, n1, n2;
	logic                  v_s3;
	dv_pay_t               pay_s3;
	dv_st_t                st_s3;

	always_comb begin
		pp = sq_pay[SQ_PAIRS].pneg ? -$signed((NUM_W+1)'(sq_pay[SQ_PAIRS].pmag))
		                           : $signed((NUM_W+1)'(sq_pay[SQ_PAIRS].pmag));
		se = $signed((NUM_W+1)'(sq_st[SQ_PAIRS].root));
		n1 = pp - se;
		n2 = pp + se;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= sq_v[SQ_PAIRS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pay_s3.kind <= sq_pay[SQ_PAIRS].kind;
			pay_s3.dmag <= sq_pay[SQ_PAIRS].dmag;
			pay_s3.neg1 <= n1[NUM_W] ^ sq_pay[SQ_PAIRS].dneg;
			pay_s3.neg2 <= n2[NUM_W] ^ sq_pay[SQ_PAIRS].dneg;
			st_s3.l1.rem <= '0;
			st_s3.l2.rem <= '0;
			st_s3.l1.nq  <= n1[NUM_W] ? NUM_W'(-n1) : NUM_W'(n1);
			st_s3.l2.nq  <= n2[NUM_W] ? NUM_W'(-n2) : NUM_W'(n2);
		end
	end

	assign dv_v[0]   = v_s3;
	assign dv_pay[0] = pay_s3;
	assign dv_st[0]  = st_s3;

	for (genvar j = 0; j < NUM_W; j++) begin : g_div
		qrs_div_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.in_valid (dv_v[j]),
			.in_pay   (dv_pay[j]),
			.in_st    (dv_st[j]),
			.out_valid(dv_v[j+1]),
			.out_pay  (dv_pay[j+1]),
			.out_st   (dv_st[j+1])
		);
	end

	logic rnd_v;
	res_t rnd_res;

	qrs_round u_round (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (dv_v[NUM_W]),
		.in_pay   (dv_pay[NUM_W]),
		.in_st    (dv_st[NUM_W]),
		.out_valid(rnd_v),
		.out_res  (rnd_res)
	);

	// sort and pack the finished beat
	logic [OUT_W-1:0] beat;
	logic             swap;

	always_comb begin
		swap = (rnd_res.r2 < rnd_res.r1);
		beat = {rnd_res.sat,
		        swap ? rnd_res.r1 : rnd_res.r2,
		        swap ? rnd_res.r2 : rnd_res.r1,
		        rnd_res.count};
	end

	logic [OUT_W-1:0] out_q, skid_q;
	logic             out_v_q, skid_v_q;
	logic             push;

	assign en       = !skid_v_q;
	assign push     = rnd_v && en;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (!out_v_q || m_tready) begin
			if (skid_v_q) begin
				out_v_q  <= 1'b1;
				skid_v_q <= 1'b0;
			end else begin
				out_v_q <= push;
			end
		end else if (push) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_v_q || m_tready) begin
			out_q <= skid_v_q ? skid_q : beat;
		end else if (push) begin
			skid_q <= beat;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = OUT_TDATA_W'(out_q);

endmodule
